>>> hdl/tlra_pkg.sv
// ----------------------------------------------------------------------------
// tlra_pkg: shared types and codes for the rule automata step block
// Opcodes, result causes, register indexes and the sequencer state type.
// ----------------------------------------------------------------------------
package tlra_pkg;

   // Operation codes of an input beat.
   typedef enum logic [2:0] {
      OP_COL_COUNT  = 3'd0,
      OP_COL_HEADER = 3'd1,
      OP_LIST_CHARS = 3'd2,
      OP_TRANSITION = 3'd3,
      OP_FINAL_FLAG = 3'd4,
      OP_START_WORD = 3'd5,
      OP_STEP       = 3'd6,
      OP_FINAL_CHK  = 3'd7
   } op_type;

   // Result causes.
   localparam logic [1:0] CAUSE_NONE      = 2'd0;
   localparam logic [1:0] CAUSE_NO_COLUMN = 2'd1;
   localparam logic [1:0] CAUSE_DEAD      = 2'd2;
   localparam logic [1:0] CAUSE_NOT_FINAL = 2'd3;

   // Configuration register indexes.
   localparam logic [0:0] CSR_RULE_ENABLE  = 1'd0;
   localparam logic [0:0] CSR_RULES_IN_USE = 1'd1;

   // Sequencer states.
   typedef enum logic [3:0] {
      ST_IDLE,
      ST_RULE,
      ST_HDR_RD,
      ST_HDR_WAIT,
      ST_SCAN_RD,
      ST_SCAN_WAIT,
      ST_TRANS_RD,
      ST_TRANS_WAIT,
      ST_FINAL_RD,
      ST_FINAL_WAIT,
      ST_DONE
   } state_type;

endpackage

>>> hdl/two_level_rule_automata_step.sv
// ----------------------------------------------------------------------------
// two_level_rule_automata_step: bank of rule automata over character pairs
// ----------------------------------------------------------------------------
// Input beats arrive on req_ (tuser = op, tdata = the other fields) and each
// one gives exactly one result beat on rsp_ (blocked rule and cause).
// Load beats write the column, list, transition and final tables; a start
// word beat sets every rule back to state 1.
// A step beat walks the enabled rules one at a time with one shared slot
// compare unit: per rule, each column in turn gets a header read and then
// a scan of its list slots, one slot at a time (slot 0 check and set scan);
// the first matching column leads to a transition read. A final check
// reads the final flag of each examined rule.
// req_tready is high only when the sequencer is idle and no result waits.
// The result sits in an output register until rsp_tready takes it; while it
// waits no new beat is accepted.
// Reset clears the configuration to all rules enabled and 16 in use, and
// sets every rule to state 1. Tables are undefined until written and get
// no clearing pass.
// ----------------------------------------------------------------------------
module two_level_rule_automata_step #(
   parameter int MAX_RULES    = 16,
   parameter int MAX_COLUMNS  = 32,
   parameter int MAX_STATES   = 32,
   parameter int MAX_LIST_LEN = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // [3:0] rule_index, [8:4] column_index, [13:9] position, [21:14] lex_char,
   // [29:22] surf_char, [30] lex_is_set, [31] surf_is_set,
   // [36:32] lex_length, [41:37] surf_length, [47:42] entry_value
   input  logic [47:0] req_tdata,
   // [2:0] op
   input  logic [2:0]  req_tuser,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // [4:0] blocked_rule, [6:5] cause
   output logic [7:0]  rsp_tdata,
   input  logic        csr_wr_en,
   input  logic [0:0]  csr_index,
   input  logic [15:0] csr_wdata
);

   localparam int RW   = $clog2(MAX_RULES) > 0 ? $clog2(MAX_RULES) : 1;
   localparam int CW   = $clog2(MAX_COLUMNS) > 0 ? $clog2(MAX_COLUMNS) : 1;
   localparam int SW   = $clog2(MAX_STATES) > 0 ? $clog2(MAX_STATES) : 1;
   localparam int LW   = $clog2(MAX_LIST_LEN) > 0 ? $clog2(MAX_LIST_LEN) : 1;
   localparam int NCOL = MAX_RULES * MAX_COLUMNS;
   localparam int HW   = $clog2(NCOL) > 0 ? $clog2(NCOL) : 1;
   localparam int LAW  = $clog2(NCOL * MAX_LIST_LEN);
   localparam int TAW  = $clog2(NCOL * MAX_STATES);
   localparam int FAW  = $clog2(MAX_RULES * MAX_STATES);
   localparam int RCW  = $clog2(MAX_RULES + 1);
   localparam int CCW  = $clog2(MAX_COLUMNS + 1);
   localparam int LCW  = $clog2(MAX_LIST_LEN + 1);

   // Field unpacking.
   tlra_pkg::op_type op;
   logic [3:0] f_rule;
   logic [4:0] f_col, f_pos, f_llen, f_slen;
   logic [7:0] f_lc, f_sc;
   logic       f_lset, f_sset;
   logic [5:0] f_ev;

   assign op     = tlra_pkg::op_type'(req_tuser);
   assign f_rule = req_tdata[3:0];
   assign f_col  = req_tdata[8:4];
   assign f_pos  = req_tdata[13:9];
   assign f_lc   = req_tdata[21:14];
   assign f_sc   = req_tdata[29:22];
   assign f_lset = req_tdata[30];
   assign f_sset = req_tdata[31];
   assign f_llen = req_tdata[36:32];
   assign f_slen = req_tdata[41:37];
   assign f_ev   = req_tdata[47:42];

   // Address range checks for loads.
   logic rok, cok, lpok, spok;
   assign rok  = 32'(f_rule) < MAX_RULES;
   assign cok  = rok && (32'(f_col) < MAX_COLUMNS);
   assign lpok = 32'(f_pos) < MAX_LIST_LEN;
   assign spok = 32'(f_pos) < MAX_STATES;

   logic accept;
   assign accept = req_tvalid && req_tready;

   // Registers.
   tlra_pkg::state_type state_ff, state_in;
   logic [15:0]    rule_enable_ff;
   logic [4:0]     rules_in_use_ff;
   logic [5:0]     cur_state_ff [MAX_RULES];
   logic [5:0]     col_total_ff [MAX_RULES];
   logic [RCW-1:0] rule_ff, rule_in;
   logic [CCW-1:0] col_ff, col_in;
   logic [LCW-1:0] slot_ff, slot_in;
   logic [7:0]     lc_ff, sc_ff;
   logic           is_step_ff;
   logic [4:0]     blocked_ff, blocked_in;
   logic [1:0]     cause_ff, cause_in;
   logic           rsp_valid_ff;

   // Column header fields read back: lset, sset, llen, slen.
   logic [11:0] hdr_rd;
   logic [7:0]  lex_rd, surf_rd;
   logic [5:0]  trans_rd;
   logic [0:0]  final_rd;
   logic [7:0]  lx0_ff, sx0_ff;

   logic [RW-1:0] rule_idx;
   logic [CW-1:0] col_idx;
   logic [LW-1:0] slot_idx;
   assign rule_idx = rule_ff[RW-1:0];
   assign col_idx  = col_ff[CW-1:0];
   assign slot_idx = slot_ff[LW-1:0];

   // Current column limits.
   logic        hl_set, hs_set;
   logic [4:0]  hl_len, hs_len;
   logic [LCW-1:0] ln, sn, scan_len;
   assign hl_set = hdr_rd[0];
   assign hs_set = hdr_rd[1];
   assign hl_len = hdr_rd[6:2];
   assign hs_len = hdr_rd[11:7];
   assign ln = (32'(hl_len) > MAX_LIST_LEN) ? LCW'(MAX_LIST_LEN) : LCW'(hl_len);
   assign sn = (32'(hs_len) > MAX_LIST_LEN) ? LCW'(MAX_LIST_LEN) : LCW'(hs_len);

   // Scan length: both sides set scans the common part; a single set side
   // scans its own list; otherwise only slot 0 counts.
   always_comb begin
      if (hl_set && hs_set) begin
         scan_len = (ln < sn) ? ln : sn;
      end else if (!hl_set && hs_set) begin
         scan_len = sn;
      end else if (hl_set && !hs_set) begin
         scan_len = ln;
      end else begin
         scan_len = LCW'(1);
      end
   end

   // Shared compare unit for one list slot.
   logic slot_hit, slot0_ok, last_slot;
   logic [7:0] lx0, sx0;
   assign lx0 = (slot_ff == '0) ? lex_rd : lx0_ff;
   assign sx0 = (slot_ff == '0) ? surf_rd : sx0_ff;
   assign slot0_ok = (ln != '0) && (sn != '0) && (lx0 == lc_ff) && (sx0 == sc_ff);
   always_comb begin
      slot_hit = 1'b0;
      if (slot_ff == '0 && slot0_ok) begin
         slot_hit = 1'b1;
      end else if (hl_set && hs_set) begin
         slot_hit = (slot_ff < scan_len) && (lex_rd == lc_ff) && (surf_rd == sc_ff);
      end else if (!hl_set && hs_set) begin
         slot_hit = (ln != '0) && (lx0 == lc_ff) && (slot_ff < sn) && (surf_rd == sc_ff);
      end else if (hl_set && !hs_set) begin
         slot_hit = (sn != '0) && (sx0 == sc_ff) && (slot_ff < ln) && (lex_rd == lc_ff);
      end
   end
   assign last_slot = (slot_ff + LCW'(1)) >= scan_len;

   // Rule and column limits.
   logic [RCW-1:0] rule_lim;
   logic [CCW-1:0] col_lim;
   logic           rule_on, st_valid;
   logic [5:0]     cur_st;
   assign rule_lim = (32'(rules_in_use_ff) > MAX_RULES) ? RCW'(MAX_RULES)
                                                       : RCW'(rules_in_use_ff);
   assign col_lim  = (32'(col_total_ff[rule_idx]) > MAX_COLUMNS) ? CCW'(MAX_COLUMNS)
                                                             : CCW'(col_total_ff[rule_idx]);
   assign rule_on  = (32'(rule_ff) >= 16) ? 1'b1 : rule_enable_ff[4'(rule_ff)];
   assign cur_st   = cur_state_ff[rule_idx];
   assign st_valid = (cur_st != '0) && (32'(cur_st) <= MAX_STATES);

   logic [SW-1:0] st_idx;
   assign st_idx = SW'(cur_st - 6'd1);

   // Memory addresses: loads write at the beat's address, reads follow
   // the sequencer.
   logic [HW-1:0]  hdr_wa, hdr_ra;
   logic [LAW-1:0] list_wa, list_ra;
   logic [TAW-1:0] tr_wa, tr_ra;
   logic [FAW-1:0] fin_wa, fin_ra;
   assign hdr_wa  = HW'({RW'(f_rule), CW'(f_col)});
   assign list_wa = LAW'({RW'(f_rule), CW'(f_col), LW'(f_pos)});
   assign tr_wa   = TAW'({RW'(f_rule), CW'(f_col), SW'(f_pos)});
   assign fin_wa  = FAW'({RW'(f_rule), SW'(f_pos)});
   assign hdr_ra  = HW'({rule_idx, col_idx});
   assign list_ra = LAW'({rule_idx, col_idx, slot_idx});
   assign tr_ra   = TAW'({rule_idx, col_idx, st_idx});
   assign fin_ra  = FAW'({rule_idx, st_idx});

   logic wr_hdr, wr_list, wr_tr, wr_fin;
   assign wr_hdr  = accept && (op == tlra_pkg::OP_COL_HEADER) && cok;
   assign wr_list = accept && (op == tlra_pkg::OP_LIST_CHARS) && cok && lpok;
   assign wr_tr   = accept && (op == tlra_pkg::OP_TRANSITION) && cok && spok;
   assign wr_fin  = accept && (op == tlra_pkg::OP_FINAL_FLAG) && rok && spok;

   tlra_ram #(.WIDTH(12), .DEPTH(NCOL)) u_hdr (
      .clock(clock), .wr_en(wr_hdr), .wr_addr(hdr_wa),
      .wr_data({f_slen, f_llen, f_sset, f_lset}), .rd_addr(hdr_ra), .rd_data(hdr_rd));
   tlra_ram #(.WIDTH(8), .DEPTH(NCOL * MAX_LIST_LEN)) u_lex (
      .clock(clock), .wr_en(wr_list), .wr_addr(list_wa), .wr_data(f_lc),
      .rd_addr(list_ra), .rd_data(lex_rd));
   tlra_ram #(.WIDTH(8), .DEPTH(NCOL * MAX_LIST_LEN)) u_surf (
      .clock(clock), .wr_en(wr_list), .wr_addr(list_wa), .wr_data(f_sc),
      .rd_addr(list_ra), .rd_data(surf_rd));
   tlra_ram #(.WIDTH(6), .DEPTH(NCOL * MAX_STATES)) u_trans (
      .clock(clock), .wr_en(wr_tr), .wr_addr(tr_wa), .wr_data(f_ev),
      .rd_addr(tr_ra), .rd_data(trans_rd));
   tlra_ram #(.WIDTH(1), .DEPTH(MAX_RULES * MAX_STATES)) u_final (
      .clock(clock), .wr_en(wr_fin), .wr_addr(fin_wa), .wr_data(f_ev != '0),
      .rd_addr(fin_ra), .rd_data(final_rd));

   // Next-state logic of the sequencer.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         tlra_pkg::ST_IDLE: begin
            if (accept) begin
               if (op == tlra_pkg::OP_STEP || op == tlra_pkg::OP_FINAL_CHK) begin
                  state_in = tlra_pkg::ST_RULE;
               end else begin
                  state_in = tlra_pkg::ST_DONE;
               end
            end
         end
         tlra_pkg::ST_RULE: begin
            if (rule_ff >= rule_lim) begin
               state_in = tlra_pkg::ST_DONE;
            end else if (!rule_on) begin
               state_in = tlra_pkg::ST_RULE;
            end else if (!is_step_ff) begin
               state_in = st_valid ? tlra_pkg::ST_FINAL_RD : tlra_pkg::ST_DONE;
            end else begin
               state_in = tlra_pkg::ST_HDR_RD;
            end
         end
         tlra_pkg::ST_HDR_RD: begin
            state_in = (col_ff >= col_lim) ? tlra_pkg::ST_DONE : tlra_pkg::ST_HDR_WAIT;
         end
         tlra_pkg::ST_HDR_WAIT:  state_in = tlra_pkg::ST_SCAN_RD;
         tlra_pkg::ST_SCAN_RD:   state_in = tlra_pkg::ST_SCAN_WAIT;
         tlra_pkg::ST_SCAN_WAIT: begin
            if (slot_hit) begin
               state_in = st_valid ? tlra_pkg::ST_TRANS_RD : tlra_pkg::ST_DONE;
            end else if (last_slot) begin
               state_in = tlra_pkg::ST_HDR_RD;
            end else begin
               state_in = tlra_pkg::ST_SCAN_RD;
            end
         end
         tlra_pkg::ST_TRANS_RD:   state_in = tlra_pkg::ST_TRANS_WAIT;
         tlra_pkg::ST_TRANS_WAIT: begin
            state_in = (trans_rd == '0) ? tlra_pkg::ST_DONE : tlra_pkg::ST_RULE;
         end
         tlra_pkg::ST_FINAL_RD:   state_in = tlra_pkg::ST_FINAL_WAIT;
         tlra_pkg::ST_FINAL_WAIT: begin
            state_in = (final_rd == 1'b1) ? tlra_pkg::ST_RULE : tlra_pkg::ST_DONE;
         end
         tlra_pkg::ST_DONE: begin
            state_in = (rsp_valid_ff && !rsp_tready) ? tlra_pkg::ST_DONE
                                                    : tlra_pkg::ST_IDLE;
         end
         default: state_in = tlra_pkg::ST_IDLE;
      endcase
   end

   // Counter and result updates of the sequencer. The result fields are
   // cleared only when a new beat is taken, so a waiting result holds.
   always_comb begin
      rule_in    = rule_ff;
      col_in     = col_ff;
      slot_in    = slot_ff;
      blocked_in = blocked_ff;
      cause_in   = cause_ff;
      unique case (state_ff)
         tlra_pkg::ST_IDLE: begin
            rule_in = '0;
            col_in  = '0;
            slot_in = '0;
            if (accept) begin
               blocked_in = '0;
               cause_in   = tlra_pkg::CAUSE_NONE;
            end
         end
         tlra_pkg::ST_RULE: begin
            col_in  = '0;
            slot_in = '0;
            if (rule_ff < rule_lim) begin
               if (!rule_on) begin
                  rule_in = rule_ff + RCW'(1);
               end else if (!is_step_ff && !st_valid) begin
                  blocked_in = 5'(rule_ff + RCW'(1));
                  cause_in   = tlra_pkg::CAUSE_NOT_FINAL;
               end
            end
         end
         tlra_pkg::ST_HDR_RD: begin
            slot_in = '0;
            if (col_ff >= col_lim) begin
               blocked_in = 5'(rule_ff + RCW'(1));
               cause_in   = tlra_pkg::CAUSE_NO_COLUMN;
            end
         end
         tlra_pkg::ST_SCAN_WAIT: begin
            if (slot_hit) begin
               if (!st_valid) begin
                  blocked_in = 5'(rule_ff + RCW'(1));
                  cause_in   = tlra_pkg::CAUSE_DEAD;
               end
            end else if (last_slot) begin
               col_in = col_ff + CCW'(1);
            end else begin
               slot_in = slot_ff + LCW'(1);
            end
         end
         tlra_pkg::ST_TRANS_WAIT: begin
            if (trans_rd == '0) begin
               blocked_in = 5'(rule_ff + RCW'(1));
               cause_in   = tlra_pkg::CAUSE_DEAD;
            end else begin
               rule_in = rule_ff + RCW'(1);
            end
         end
         tlra_pkg::ST_FINAL_WAIT: begin
            if (final_rd == 1'b1) begin
               rule_in = rule_ff + RCW'(1);
            end else begin
               blocked_in = 5'(rule_ff + RCW'(1));
               cause_in   = tlra_pkg::CAUSE_NOT_FINAL;
            end
         end
         default: ;
      endcase
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= tlra_pkg::ST_IDLE;
         rule_enable_ff  <= 16'hFFFF;
         rules_in_use_ff <= 5'd16;
         rsp_valid_ff    <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (csr_wr_en && csr_index == tlra_pkg::CSR_RULE_ENABLE) begin
            rule_enable_ff <= csr_wdata;
         end
         if (csr_wr_en && csr_index == tlra_pkg::CSR_RULES_IN_USE) begin
            rules_in_use_ff <= csr_wdata[4:0];
         end
         if (state_ff == tlra_pkg::ST_DONE && !rsp_valid_ff) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_valid_ff && rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // Rule states: reset and start word set all to 1; a step writes the
   // transition result or 0 when the state itself is invalid.
   always_ff @(posedge clock) begin
      for (int r = 0; r < MAX_RULES; r++) begin
         if (reset || (accept && op == tlra_pkg::OP_START_WORD)) begin
            cur_state_ff[r] <= 6'd1;
         end else if (r == 32'(rule_idx) && state_ff == tlra_pkg::ST_TRANS_WAIT) begin
            cur_state_ff[r] <= trans_rd;
         end else if (r == 32'(rule_idx) && state_ff == tlra_pkg::ST_SCAN_WAIT
                      && slot_hit && !st_valid) begin
            cur_state_ff[r] <= 6'd0;
         end
      end
   end

   // Payload and working registers.
   always_ff @(posedge clock) begin
      if (accept && op == tlra_pkg::OP_COL_COUNT && rok) begin
         col_total_ff[RW'(f_rule)] <= f_ev;
      end
      if (accept) begin
         lc_ff      <= f_lc;
         sc_ff      <= f_sc;
         is_step_ff <= (op == tlra_pkg::OP_STEP);
      end
      if (state_ff == tlra_pkg::ST_SCAN_WAIT && slot_ff == '0) begin
         lx0_ff <= lex_rd;
         sx0_ff <= surf_rd;
      end
      rule_ff <= rule_in;
      col_ff  <= col_in;
      slot_ff <= slot_in;
      if (state_ff != tlra_pkg::ST_DONE) begin
         blocked_ff <= blocked_in;
         cause_ff   <= cause_in;
      end
   end

   assign req_tready = (state_ff == tlra_pkg::ST_IDLE) && !rsp_valid_ff;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {1'b0, cause_ff, blocked_ff};

endmodule

>>> hdl/tlra_ram.sv
// ----------------------------------------------------------------------------
// tlra_ram: generic simple dual-port RAM
// One write and one read port, read data registered.
// ----------------------------------------------------------------------------
module tlra_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port and registered read.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

>>> hdl/tlra_checker.sv
// ----------------------------------------------------------------------------
// tlra_checker: port checks for the rule automata step block
// Watches the handshakes and result codes on the top level's ports.
// ----------------------------------------------------------------------------
module tlra_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [7:0]  rsp_tdata
);

   // A result never waits while a new beat is taken.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> !req_tready)
      else $error("input accepted while result pending");

   // A stalled result holds its data.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("stalled result changed");

   // A zero rule number always pairs with no cause, and back.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> ((rsp_tdata[4:0] == 5'd0) == (rsp_tdata[6:5] == 2'd0)))
      else $error("rule and cause disagree");

   // An accepted beat is not followed at once by another.
   assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("back to back accept");

endmodule

bind two_level_rule_automata_step tlra_checker u_tlra_checker (
   .clock(clock), .reset(reset), .req_tvalid(req_tvalid), .req_tready(req_tready),
   .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata));
